/* src/msbp_pkg.sv */
// Shared constants and types for the MSB-first bit packer.
`timescale 1ns / 1ps

package msbp_pkg;

    localparam int DATA_W   = 64;
    localparam int LOG_DATA = $clog2(DATA_W);
    localparam int NUM_W    = 7;
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 3;
    localparam int PEND_W   = BYTE_W - 1;

    localparam logic [MODE_W-1:0] MODE_FIELD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIG   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    // Control that travels with a request from the width stage to the packer.
    typedef struct packed {
        logic valid;
        logic flush;
    } item_ctl_t;

endpackage

/* src/msbp_front.sv */
// Input register and field width stage: resolves the bit count and masks the field.
`timescale 1ns / 1ps

module msbp_front #(
    parameter int MAX_FIELD_BITS = 64,
    parameter int NW = $clog2(MAX_FIELD_BITS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [msbp_pkg::MODE_W-1:0]  mode,
    input  logic [msbp_pkg::DATA_W-1:0]  data,
    input  logic [msbp_pkg::NUM_W-1:0]   num_bits,
    input  logic                         pass_ready,
    output msbp_pkg::item_ctl_t          item_ctl,
    output logic [MAX_FIELD_BITS-1:0]    item_field,
    output logic [NW-1:0]                item_n
);
    import msbp_pkg::*;

    // Position of the highest set bit plus one, found by halving search.
    function automatic logic [NUM_W-1:0] sig_count(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] t;
        logic [NUM_W-1:0]  pos;
        begin
            t   = v;
            pos = '0;
            for (int s = LOG_DATA - 1; s >= 0; s--) begin
                if ((t >> (1 << s)) != '0) begin
                    pos = pos + NUM_W'(1 << s);
                    t   = t >> (1 << s);
                end
            end
            sig_count = (v == '0) ? '0 : pos + NUM_W'(1);
        end
    endfunction

    logic                       a_v_reg, a_v_next;
    logic [MODE_W-1:0]          a_mode_reg;
    logic [DATA_W-1:0]          a_data_reg;
    logic [NUM_W-1:0]           a_num_reg;

    logic                       b_v_reg, b_v_next;
    logic                       b_flush_reg, b_flush_next;
    logic [MAX_FIELD_BITS-1:0]  b_field_reg, b_field_next;
    logic [NW-1:0]              b_n_reg, b_n_next;

    logic                       b_free;
    logic [NUM_W-1:0]           n_raw, n_sat;
    logic [NW-1:0]              n_use;

    assign b_free   = !b_v_reg || pass_ready;
    assign in_ready = !a_v_reg || b_free;
    assign a_v_next = in_ready ? in_valid : a_v_reg;
    assign b_v_next = b_free ? a_v_reg : b_v_reg;

    always_comb
    begin
        n_raw = (a_mode_reg == MODE_SIG) ? sig_count(a_data_reg) : a_num_reg;
        n_sat = (n_raw > NUM_W'(MAX_FIELD_BITS)) ? NUM_W'(MAX_FIELD_BITS) : n_raw;
        unique case (a_mode_reg)
            MODE_FIELD, MODE_SIG:
            begin
                n_use        = NW'(n_sat);
                b_flush_next = 1'b0;
            end
            MODE_FLUSH:
            begin
                n_use        = '0;
                b_flush_next = 1'b1;
            end
            default:
            begin
                n_use        = '0;
                b_flush_next = 1'b0;
            end
        endcase
        b_n_next     = n_use;
        b_field_next = a_data_reg[MAX_FIELD_BITS-1:0] & ~({MAX_FIELD_BITS{1'b1}} << n_use);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            a_mode_reg <= mode;
            a_data_reg <= data;
            a_num_reg  <= num_bits;
        end
        if (b_free)
        begin
            b_flush_reg <= b_flush_next;
            b_field_reg <= b_field_next;
            b_n_reg     <= b_n_next;
        end
    end

    assign item_ctl.valid = b_v_reg;
    assign item_ctl.flush = b_flush_reg;
    assign item_field     = b_field_reg;
    assign item_n         = b_n_reg;

endmodule

/* src/msbp_pack.sv */
// Packer stage: merges pending bits with the field and left-aligns completed bytes.
`timescale 1ns / 1ps

module msbp_pack #(
    parameter int MAX_FIELD_BITS = 64,
    parameter int NW = $clog2(MAX_FIELD_BITS + 1),
    parameter int OW = ((MAX_FIELD_BITS + 7) / 8) * 8,
    parameter int KW = $clog2((MAX_FIELD_BITS + 7) / 8 + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  msbp_pkg::item_ctl_t          item_ctl,
    input  logic [MAX_FIELD_BITS-1:0]    item_field,
    input  logic [NW-1:0]                item_n,
    output logic                         pass_ready,
    input  logic                         emit_can_load,
    output logic                         emit_load,
    output logic [OW-1:0]                emit_word,
    output logic [KW-1:0]                emit_count
);
    import msbp_pkg::*;

    localparam int AW   = MAX_FIELD_BITS + PEND_W;
    localparam int KMAX = AW / BYTE_W;
    localparam int TW   = $clog2(MAX_FIELD_BITS + BYTE_W);

    logic [PEND_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [NW-1:0]     pad_n, n_eff;
    logic [AW-1:0]     merged, aligned;
    logic [TW-1:0]     total;
    logic [KW-1:0]     k;
    logic [CNT_W-1:0]  rem;
    logic              fire;

    always_comb
    begin
        // Flush writes just enough zeros to close the partial byte.
        pad_n   = (cnt_reg == '0) ? '0 : NW'(BYTE_W) - NW'(cnt_reg);
        n_eff   = item_ctl.flush ? pad_n : item_n;
        merged  = (AW'(acc_reg) << n_eff) | AW'(item_field);
        total   = TW'(cnt_reg) + TW'(n_eff);
        k       = KW'(total >> CNT_W);
        rem     = total[CNT_W-1:0];
        aligned = merged << (TW'(AW) - total);
        acc_next = merged[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
        cnt_next = rem;
    end

    assign pass_ready = (k == '0) || emit_can_load;
    assign fire       = item_ctl.valid && pass_ready;
    assign emit_load  = fire && (k != '0);
    assign emit_word  = aligned[AW-1 -: OW];
    assign emit_count = k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (fire)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg & ({PEND_W{1'b1}} << cnt_reg)) == '0)
        else $error("pending bits set above pending count");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_ctl.flush |=> cnt_reg == '0)
        else $error("flush left bits pending");

    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> emit_can_load)
        else $error("byte run loaded while emitter busy");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> k <= KW'(KMAX))
        else $error("byte run longer than emitter holds");

endmodule

/* src/msbp_emit.sv */
// Byte emitter: holds one run of completed bytes and sends them one per cycle while out_ready is high.
`timescale 1ns / 1ps

module msbp_emit #(
    parameter int OW = 72,
    parameter int KW = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         emit_load,
    input  logic [OW-1:0]                emit_word,
    input  logic [KW-1:0]                emit_count,
    output logic                         emit_can_load,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [msbp_pkg::BYTE_W-1:0]  out_byte,
    output logic                         last_of_run
);
    import msbp_pkg::*;

    logic [OW-1:0] word_reg, word_next;
    logic [KW-1:0] left_reg, left_next;
    logic          send;

    assign out_valid     = (left_reg != '0);
    assign send          = out_valid && out_ready;
    assign last_of_run   = (left_reg == KW'(1));
    assign out_byte      = word_reg[OW-1 -: BYTE_W];
    assign emit_can_load = (left_reg == '0) || (last_of_run && out_ready);

    always_comb
    begin
        word_next = word_reg;
        left_next = left_reg;
        if (emit_load)
        begin
            word_next = emit_word;
            left_next = emit_count;
        end
        else if (send)
        begin
            // Advance to the next byte of the run.
            word_next = word_reg << BYTE_W;
            left_next = left_reg - KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else
            left_reg <= left_next;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

/* src/msb_first_bit_packer_top.sv */
// Path: the first byte of a request passes the input register, the width register and the byte
// emitter before it is offered. Throughput: one request per cycle while each yields at most one
// byte and out_ready is high; a request that completes more than one byte stalls the next one that
// completes bytes until the byte emitter, sending one per cycle while out_ready is high, is on its last.
// Reset: asynchronous, active low; clears the pending bits, pending count and all valid flags.
`timescale 1ns / 1ps

module msb_first_bit_packer_top #(
    parameter int MAX_FIELD_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [msbp_pkg::MODE_W-1:0]  mode,
    input  logic [msbp_pkg::DATA_W-1:0]  data,
    input  logic [msbp_pkg::NUM_W-1:0]   num_bits,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [msbp_pkg::BYTE_W-1:0]  out_byte,
    output logic                         last_of_run
);
    import msbp_pkg::*;

    localparam int NW = $clog2(MAX_FIELD_BITS + 1);
    localparam int OW = ((MAX_FIELD_BITS + PEND_W) / BYTE_W) * BYTE_W;
    localparam int KW = $clog2((MAX_FIELD_BITS + PEND_W) / BYTE_W + 1);

    item_ctl_t                  item_ctl;
    logic [MAX_FIELD_BITS-1:0]  item_field;
    logic [NW-1:0]              item_n;
    logic                       pass_ready;
    logic                       emit_can_load;
    logic                       emit_load;
    logic [OW-1:0]              emit_word;
    logic [KW-1:0]              emit_count;

    msbp_front #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .NW(NW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .data(data),
        .num_bits(num_bits),
        .pass_ready(pass_ready),
        .item_ctl(item_ctl),
        .item_field(item_field),
        .item_n(item_n)
    );

    msbp_pack #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .NW(NW),
        .OW(OW),
        .KW(KW)
    ) u_pack (
        .clk(clk),
        .rst_n(rst_n),
        .item_ctl(item_ctl),
        .item_field(item_field),
        .item_n(item_n),
        .pass_ready(pass_ready),
        .emit_can_load(emit_can_load),
        .emit_load(emit_load),
        .emit_word(emit_word),
        .emit_count(emit_count)
    );

    msbp_emit #(
        .OW(OW),
        .KW(KW)
    ) u_emit (
        .clk(clk),
        .rst_n(rst_n),
        .emit_load(emit_load),
        .emit_word(emit_word),
        .emit_count(emit_count),
        .emit_can_load(emit_can_load),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .last_of_run(last_of_run)
    );

endmodule

/* bench/msb_first_bit_packer_top_tb.sv */
// Self-checking testbench for the MSB-first bit packer: directed and random requests.
`timescale 1ns / 1ps

module msb_first_bit_packer_top_tb;

    import msbp_pkg::*;

    localparam int                FIELD_LIMIT  = 64;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam int                RANDOM_REQS  = 300;
    localparam int                BURST_REQS   = 60;
    localparam int                SETTLE_CYCLES = 10;
    localparam int                CYCLE_LIMIT  = 400000;
    localparam int                MAX_REPORTS  = 10;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last_flag;
    } packed_byte_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [MODE_W-1:0]   mode;
    logic [DATA_W-1:0]   data;
    logic [NUM_W-1:0]    num_bits;
    logic                out_valid;
    logic                out_ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                last_of_run;

    // Packer model state
    logic [PEND_W-1:0]   held_bits;
    int                  held_count;

    packed_byte_t        byte_q[$];
    packed_byte_t        byte_head;
    int                  mismatches;
    int                  bytes_checked;
    int                  cycle_count;
    int                  reqs_by_mode[4];
    int                  runs_completed;
    bit                  quiet_phase;

    msb_first_bit_packer_top #(
        .MAX_FIELD_BITS(FIELD_LIMIT)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .data       (data),
        .num_bits   (num_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last_of_run(last_of_run)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Work out the bytes a request completes and queue them in order.
    function automatic void predict_bytes(input logic [MODE_W-1:0] m,
                                          input logic [DATA_W-1:0] d,
                                          input logic [NUM_W-1:0]  nb);
        logic [BYTE_W-1:0] acc;
        int                cnt;
        int                width;
        int                made;
        packed_byte_t      run[$];
        packed_byte_t      one;
        acc   = {1'b0, held_bits};
        cnt   = held_count;
        width = 0;
        made  = 0;
        if (m == MODE_UNUSED)
            return;
        if (m == MODE_FLUSH)
        begin
            if (cnt != 0)
            begin
                one.value     = acc << (BYTE_W - cnt);
                one.last_flag = 1'b1;
                byte_q = {byte_q, one};
                runs_completed++;
            end
            held_bits  = '0;
            held_count = 0;
            return;
        end
        if (m == MODE_SIG)
        begin
            for (int i = 0; i < DATA_W; i++)
                if (d[i])
                    width = i + 1;
        end
        else
            width = int'(nb);
        if (width > FIELD_LIMIT)
            width = FIELD_LIMIT;
        for (int i = width - 1; i >= 0; i--)
        begin
            acc = {acc[BYTE_W-2:0], d[i]};
            cnt++;
            if (cnt == BYTE_W)
            begin
                one.value     = acc;
                one.last_flag = 1'b0;
                run = {run, one};
                acc = '0;
                cnt = 0;
            end
        end
        if (run.size() > 0)
        begin
            run[run.size()-1].last_flag = 1'b1;
            runs_completed++;
        end
        foreach (run[i])
            byte_q = {byte_q, run[i]};
        held_bits  = acc[PEND_W-1:0];
        held_count = cnt;
    endfunction

    task automatic send_req(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] d,
                            input logic [NUM_W-1:0] nb);
        in_valid <= 1'b1;
        mode     <= m;
        data     <= d;
        num_bits <= nb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_bytes(m, d, nb);
        reqs_by_mode[m]++;
        if (!quiet_phase && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop valid and hold until every queued byte is out, then let the design settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_random_req();
        int                r;
        logic [MODE_W-1:0] m;
        logic [DATA_W-1:0] d;
        logic [NUM_W-1:0]  nb;
        r = $urandom_range(0, 99);
        if (r < 55)
            m = MODE_FIELD;
        else if (r < 80)
            m = MODE_SIG;
        else if (r < 94)
            m = MODE_FLUSH;
        else
            m = MODE_UNUSED;
        d = rand_word();
        // Vary the top set bit so significant-bit writes cover every width
        if ($urandom_range(0, 1))
            d = d >> $urandom_range(0, DATA_W - 1);
        if ($urandom_range(0, 19) == 0)
            d = '0;
        r = $urandom_range(0, 99);
        if (r < 60)
            nb = NUM_W'($urandom_range(0, 12));
        else if (r < 85)
            nb = NUM_W'($urandom_range(13, FIELD_LIMIT));
        else
            nb = NUM_W'($urandom_range(FIELD_LIMIT + 1, (1 << NUM_W) - 1));
        send_req(m, d, nb);
    endtask

    task automatic test_field_widths();
        send_req(MODE_FIELD, '1, 7'd64);
        send_req(MODE_FIELD, 64'hA5C3_0F1E_7788_99AA, 7'd127);
        send_req(MODE_FIELD, 64'h0123_4567_89AB_CDEF, 7'd65);
        send_req(MODE_FIELD, '1, 7'd0);
        send_req(MODE_FIELD, 64'h5, 7'd3);
        send_req(MODE_FIELD, 64'h0, 7'd4);
        // seven held bits plus 57 new ones makes exactly eight bytes
        send_req(MODE_FIELD, 64'h0155_AA55_AA55_AA55, 7'd57);
        send_req(MODE_FIELD, 64'h7F, 7'd7);
        send_req(MODE_FIELD, '1, 7'd64);
        send_req(MODE_FLUSH, '0, 7'd0);
    endtask

    task automatic test_significant_bits();
        send_req(MODE_SIG, 64'h0, 7'd0);
        send_req(MODE_SIG, 64'h1, 7'd9);
        send_req(MODE_SIG, 64'h8000_0000_0000_0000, 7'd0);
        send_req(MODE_SIG, '1, 7'd127);
        send_req(MODE_SIG, 64'h0000_0000_0001_2345, 7'd1);
    endtask

    task automatic test_flush_and_unused();
        send_req(MODE_FLUSH, '1, 7'd64);
        send_req(MODE_FLUSH, '0, 7'd0);
        send_req(MODE_FIELD, 64'h15, 7'd5);
        send_req(MODE_UNUSED, '1, 7'd127);
        send_req(MODE_FIELD, 64'h6, 7'd3);
        send_req(MODE_FIELD, 64'h1, 7'd1);
        send_req(MODE_FLUSH, '0, 7'd0);
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            send_random_req();
            if (mode != MODE_UNUSED || $urandom_range(0, 0) == 1)
                sent++;
            if (!quiet_phase && $urandom_range(0, 99) == 0)
                wait_drained();
        end
    endtask

    task automatic test_back_to_back(input int count);
        quiet_phase = 1'b1;
        test_random_traffic(count);
        quiet_phase = 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [BYTE_W-1:0] exp_val,
                                 input logic exp_last);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, what, exp_val, exp_last, out_byte, last_of_run);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            bytes_checked++;
            if (byte_q.size() == 0)
                note_mismatch("unexpected byte", '0, 1'b0);
            else
            begin
                byte_head = byte_q.pop_front();
                if (out_byte !== byte_head.value || last_of_run !== byte_head.last_flag)
                    note_mismatch("byte mismatch", byte_head.value, byte_head.last_flag);
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_phase)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 15);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still queued",
                     cycle_count, byte_q.size());
            $display("msb_first_bit_packer_top verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_FIELD;
        data          = '0;
        num_bits      = '0;
        out_ready     = 1'b0;
        held_bits     = '0;
        held_count    = 0;
        mismatches    = 0;
        bytes_checked = 0;
        cycle_count   = 0;
        runs_completed = 0;
        quiet_phase   = 1'b0;
        foreach (reqs_by_mode[i])
            reqs_by_mode[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_widths();
        test_significant_bits();
        test_flush_and_unused();
        wait_drained();
        test_random_traffic(RANDOM_REQS / 2);
        test_back_to_back(BURST_REQS);
        test_random_traffic(RANDOM_REQS - RANDOM_REQS / 2);
        wait_drained();

        if (byte_q.size() != 0)
            mismatches++;
        $display("requests: %0d field, %0d significant-bit, %0d flush, %0d unused mode",
                 reqs_by_mode[MODE_FIELD], reqs_by_mode[MODE_SIG],
                 reqs_by_mode[MODE_FLUSH], reqs_by_mode[MODE_UNUSED]);
        $display("checked %0d bytes over %0d runs with random stalls, %0d mismatches",
                 bytes_checked, runs_completed, mismatches);
        if (mismatches == 0)
            $display("msb_first_bit_packer_top verification clean");
        else
            $display("msb_first_bit_packer_top verification failed");
        $finish;
    end

endmodule
